### rtl/qrs_pkg.sv
// qrs_pkg: widths, result kind codes and pipeline payload types of the
// quadratic root solver; no dependencies
package qrs_pkg;

  localparam int CoefW = 16;
  localparam int RadW  = 50;
  localparam int RootW = 25;
  localparam int RemW  = 28;
  localparam int NumW  = 27;
  localparam int DivW  = 34;
  localparam int DvsW  = 17;
  localparam int DremW = 18;
  localparam int OutW  = 40;

  typedef enum logic [1:0] {
    KindTwoReal = 2'd0,
    KindDouble  = 2'd1,
    KindComplex = 2'd2,
    KindZeroA   = 2'd3
  } root_kind_e;

  typedef struct packed {
    root_kind_e              kind;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic [RadW-1:0]         rad;
    logic [RemW-1:0]         rem;
    logic [RootW-1:0]        root;
  } sqrt_t;

  typedef struct packed {
    root_kind_e       kind;
    logic             neg1;
    logic             neg2;
    logic [DvsW-1:0]  dvs;
    logic [DivW-1:0]  n1;
    logic [DivW-1:0]  n2;
    logic [DremW-1:0] r1;
    logic [DremW-1:0] r2;
  } div_t;

endpackage

### rtl/qrs_if.sv
// qrs_in_if / qrs_out_if: valid-ready channels for coefficients and roots
// depends on qrs_pkg
interface qrs_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [qrs_pkg::CoefW-1:0] coef_a;
  logic signed [qrs_pkg::CoefW-1:0] coef_b;
  logic signed [qrs_pkg::CoefW-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      root_kind;
  logic signed [qrs_pkg::OutW-1:0] first_value;
  logic signed [qrs_pkg::OutW-1:0] second_value;
  modport source (output valid, root_kind, first_value, second_value, input ready);
  modport sink (input valid, root_kind, first_value, second_value, output ready);
endinterface

### rtl/qrs_sqrt_cell.sv
// qrs_sqrt_cell: one root digit of the pipelined restoring square root
// depends on qrs_pkg
module qrs_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  qrs_pkg::sqrt_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output qrs_pkg::sqrt_t data_o,
  input  logic          ready_i
);

  logic                      valid_q;
  qrs_pkg::sqrt_t            data_q;
  qrs_pkg::sqrt_t            data_d;
  logic [qrs_pkg::RemW+1:0]  rp;
  logic [qrs_pkg::RemW+1:0]  trial;
  logic                      ge;

  always_comb begin
    rp     = {data_i.rem, data_i.rad[qrs_pkg::RadW-1 -: 2]};
    trial  = (qrs_pkg::RemW+2)'({data_i.root, 2'b01});
    ge     = (rp >= trial);
    data_d = data_i;
    data_d.rad = data_i.rad << 2;
    if (ge) begin
      data_d.rem  = qrs_pkg::RemW'(rp - trial);
      data_d.root = {data_i.root[qrs_pkg::RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = rp[qrs_pkg::RemW-1:0];
      data_d.root = {data_i.root[qrs_pkg::RootW-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/qrs_div_cell.sv
// qrs_div_cell: one quotient bit of two restoring dividers sharing a divisor
// depends on qrs_pkg
module qrs_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  qrs_pkg::div_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  output qrs_pkg::div_t data_o,
  input  logic         ready_i
);

  logic                      valid_q;
  qrs_pkg::div_t             data_q;
  qrs_pkg::div_t             data_d;
  logic [qrs_pkg::DremW-1:0] rp1;
  logic [qrs_pkg::DremW-1:0] rp2;
  logic [qrs_pkg::DremW-1:0] dv;
  logic                      ge1;
  logic                      ge2;

  always_comb begin
    dv     = qrs_pkg::DremW'(data_i.dvs);
    rp1    = {data_i.r1[qrs_pkg::DremW-2:0], data_i.n1[qrs_pkg::DivW-1]};
    rp2    = {data_i.r2[qrs_pkg::DremW-2:0], data_i.n2[qrs_pkg::DivW-1]};
    ge1    = (rp1 >= dv);
    ge2    = (rp2 >= dv);
    data_d = data_i;
    data_d.r1 = ge1 ? rp1 - dv : rp1;
    data_d.r2 = ge2 ? rp2 - dv : rp2;
    data_d.n1 = {data_i.n1[qrs_pkg::DivW-2:0], ge1};
    data_d.n2 = {data_i.n2[qrs_pkg::DivW-2:0], ge2};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/quadratic_root_solver_top.sv
// quadratic_root_solver_top: discriminant, square root cell chain, divider cell chain
// depends on qrs_pkg, qrs_if, qrs_sqrt_cell, qrs_div_cell
//
//   channel  dir  payload                                     handshake
//   in_i     in   coef_a, coef_b, coef_c (signed Q8.8)        valid/ready
//   out_o    out  root_kind, first_value, second_value Q24.16 valid/ready
//
// stages in order: product stage, discriminant stage, 25 root cells,
// numerator stage, 34 quotient cells, output register
// one transaction per cycle while out_o is ready; each stage fills bubbles on its own
// a stalled output holds only the stages behind it that are full
// reset clears the valid bits only
module quadratic_root_solver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_in_if.sink     in_i,
  qrs_out_if.source  out_o
);

  // product stage
  logic                              v1_q;
  logic                              rdy1;
  logic signed [2*qrs_pkg::CoefW-1:0] bb1_q;
  logic signed [2*qrs_pkg::CoefW-1:0] ac1_q;
  logic signed [qrs_pkg::CoefW-1:0]   a1_q;
  logic signed [qrs_pkg::CoefW-1:0]   b1_q;

  // discriminant stage
  logic                              v2_q;
  logic                              rdy2;
  qrs_pkg::sqrt_t                    sq2_q;
  qrs_pkg::sqrt_t                    sq2_d;
  logic signed [2*qrs_pkg::CoefW+1:0] disc;
  logic [2*qrs_pkg::CoefW+1:0]        disc_mag;

  logic           sq_v   [qrs_pkg::RootW+1];
  logic           sq_rdy [qrs_pkg::RootW+1];
  qrs_pkg::sqrt_t sq_d   [qrs_pkg::RootW+1];

  // numerator stage
  logic                          v3_q;
  logic                          rdy3;
  qrs_pkg::div_t                 dv3_q;
  qrs_pkg::div_t                 dv3_d;
  qrs_pkg::sqrt_t                sq_e;
  logic signed [qrs_pkg::NumW-1:0] nb;
  logic signed [qrs_pkg::NumW-1:0] sr;
  logic signed [qrs_pkg::NumW-1:0] n1;
  logic signed [qrs_pkg::NumW-1:0] n2;
  logic [qrs_pkg::NumW-1:0]        m1;
  logic [qrs_pkg::NumW-1:0]        m2;
  logic [qrs_pkg::CoefW-1:0]       a_mag;

  logic          dv_v   [qrs_pkg::DivW+1];
  logic          dv_rdy [qrs_pkg::DivW+1];
  qrs_pkg::div_t dv_d   [qrs_pkg::DivW+1];

  // output register
  logic                            v4_q;
  logic                            rdy4;
  qrs_pkg::root_kind_e             kind4_q;
  logic signed [qrs_pkg::OutW-1:0] f4_q;
  logic signed [qrs_pkg::OutW-1:0] s4_q;
  qrs_pkg::div_t                   dv_e;
  logic signed [qrs_pkg::OutW-1:0] q1;
  logic signed [qrs_pkg::OutW-1:0] q2;

  assign rdy1 = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      bb1_q <= (2*qrs_pkg::CoefW)'(in_i.coef_b) * (2*qrs_pkg::CoefW)'(in_i.coef_b);
      ac1_q <= (2*qrs_pkg::CoefW)'(in_i.coef_a) * (2*qrs_pkg::CoefW)'(in_i.coef_c);
      a1_q  <= in_i.coef_a;
      b1_q  <= in_i.coef_b;
    end
  end

  always_comb begin
    disc     = (2*qrs_pkg::CoefW+2)'(bb1_q) - ((2*qrs_pkg::CoefW+2)'(ac1_q) <<< 2);
    disc_mag = disc[2*qrs_pkg::CoefW+1] ? -disc : disc;
    sq2_d.a    = a1_q;
    sq2_d.b    = b1_q;
    sq2_d.rad  = qrs_pkg::RadW'({disc_mag, 16'd0});
    sq2_d.rem  = '0;
    sq2_d.root = '0;
    if (a1_q == '0) begin
      sq2_d.kind = qrs_pkg::KindZeroA;
    end else if (disc[2*qrs_pkg::CoefW+1]) begin
      sq2_d.kind = qrs_pkg::KindComplex;
    end else if (disc == '0) begin
      sq2_d.kind = qrs_pkg::KindDouble;
    end else begin
      sq2_d.kind = qrs_pkg::KindTwoReal;
    end
  end

  assign rdy2 = !v2_q || sq_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sq2_q <= sq2_d;
    end
  end

  assign sq_v[0] = v2_q;
  assign sq_d[0] = sq2_q;
  assign sq_rdy[qrs_pkg::RootW] = rdy3;

  for (genvar i = 0; i < qrs_pkg::RootW; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .data_i  (sq_d[i]),
      .ready_o (sq_rdy[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_d[i+1]),
      .ready_i (sq_rdy[i+1])
    );
  end

  always_comb begin
    sq_e  = sq_d[qrs_pkg::RootW];
    nb    = -(qrs_pkg::NumW'(sq_e.b) <<< 8);
    sr    = qrs_pkg::NumW'(sq_e.root);
    n1    = (sq_e.kind == qrs_pkg::KindTwoReal) ? nb + sr : nb;
    n2    = (sq_e.kind == qrs_pkg::KindComplex) ? sr : nb - sr;
    m1    = n1[qrs_pkg::NumW-1] ? -n1 : n1;
    m2    = n2[qrs_pkg::NumW-1] ? -n2 : n2;
    a_mag = sq_e.a[qrs_pkg::CoefW-1] ? -sq_e.a : sq_e.a;
    dv3_d.kind = sq_e.kind;
    dv3_d.neg1 = n1[qrs_pkg::NumW-1] ^ sq_e.a[qrs_pkg::CoefW-1];
    dv3_d.neg2 = (sq_e.kind == qrs_pkg::KindComplex) ? 1'b0
                 : (n2[qrs_pkg::NumW-1] ^ sq_e.a[qrs_pkg::CoefW-1]);
    dv3_d.dvs  = {a_mag, 1'b0};
    dv3_d.n1   = qrs_pkg::DivW'({m1, 8'd0});
    dv3_d.n2   = qrs_pkg::DivW'({m2, 8'd0});
    dv3_d.r1   = '0;
    dv3_d.r2   = '0;
  end

  assign rdy3 = !v3_q || dv_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= sq_v[qrs_pkg::RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && sq_v[qrs_pkg::RootW]) begin
      dv3_q <= dv3_d;
    end
  end

  assign dv_v[0] = v3_q;
  assign dv_d[0] = dv3_q;
  assign dv_rdy[qrs_pkg::DivW] = rdy4;

  for (genvar j = 0; j < qrs_pkg::DivW; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .data_i  (dv_d[j]),
      .ready_o (dv_rdy[j]),
      .valid_o (dv_v[j+1]),
      .data_o  (dv_d[j+1]),
      .ready_i (dv_rdy[j+1])
    );
  end

  always_comb begin
    dv_e = dv_d[qrs_pkg::DivW];
    q1   = qrs_pkg::OutW'(dv_e.n1);
    q2   = qrs_pkg::OutW'(dv_e.n2);
    if (dv_e.neg1) begin
      q1 = -q1;
    end
    if (dv_e.neg2) begin
      q2 = -q2;
    end
    if (dv_e.kind == qrs_pkg::KindZeroA) begin
      q1 = '0;
      q2 = '0;
    end
  end

  assign rdy4 = !v4_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= dv_v[qrs_pkg::DivW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && dv_v[qrs_pkg::DivW]) begin
      kind4_q <= dv_e.kind;
      f4_q    <= q1;
      s4_q    <= q2;
    end
  end

  assign out_o.valid        = v4_q;
  assign out_o.root_kind    = kind4_q;
  assign out_o.first_value  = f4_q;
  assign out_o.second_value = s4_q;

  a_zero_a_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && kind4_q == qrs_pkg::KindZeroA |-> f4_q == '0 && s4_q == '0)
    else $error("leading zero coefficient with nonzero roots");

  a_imag_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && kind4_q == qrs_pkg::KindComplex |-> !s4_q[qrs_pkg::OutW-1])
    else $error("negative imaginary part");

  a_double_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && kind4_q == qrs_pkg::KindDouble |-> f4_q == s4_q)
    else $error("double root values differ");

  a_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_i.ready)
    else $error("empty front stage refuses a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_o.ready |=> v4_q && $stable(f4_q) && $stable(s4_q))
    else $error("stalled result changed");

endmodule
